// ===== rtl/asp_pkg.sv =====
// shared constants and types for the antialiased segment plotter
// no dependencies
package asp_pkg;
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 4;
    localparam int DIR_BITS   = 15;
    localparam int POS_BITS   = FRAC_BITS + DIR_BITS;
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int COORD_W    = 14;
    localparam int DIM_W      = 10;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
endpackage

// ===== rtl/asp_divider.sv =====
// restoring divider, one quotient bit per cycle, signed dividend magnitude
// depends on asp_pkg
module asp_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [30:0] o_quot
);
    import asp_pkg::*;
    logic [30:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [16:0] w_trial;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem[15:0], r_q[30]};
        if (i_start) begin
            n_q = i_num; n_rem = '0; n_cnt = 5'd30; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem = w_trial - {1'b0, i_den};
                n_q = {r_q[29:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q = {r_q[29:0], 1'b0};
            end
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0; n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_rem <= n_rem; r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== rtl/antialiased_segment_plotter.sv =====
// antialiased segment plotter: 8-bit framebuffer in one synchronous ram
// depends on asp_pkg and asp_divider
// clear writes one entry per cycle; read passes through RREAD, RWAIT and DONE
// draw: square root and two divisions, then a POS, FRAC and CORN pass per half-pixel
// sample (four read-modify-writes on the single ram port); one item at a time
// reset sweeps the ram to zero with busy high
module antialiased_segment_plotter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic signed [13:0]            i_start_x,
    input  logic signed [13:0]            i_start_y,
    input  logic signed [13:0]            i_end_x,
    input  logic signed [13:0]            i_end_y,
    input  logic [17:0]                   i_read_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [asp_pkg::DIM_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic [7:0]                    o_pixel_value,
    output logic [1:0]                    o_done_op
);
    import asp_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CLEAR = 11'b00000000010,
        S_RREAD = 11'b00000000100,
        S_RWAIT = 11'b00000001000,
        S_SQRT  = 11'b00000010000,
        S_DIVX  = 11'b00000100000,
        S_DIVY  = 11'b00001000000,
        S_POS   = 11'b00010000000,
        S_FRAC  = 11'b00100000000,
        S_CORN  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [7:0] r_mem [STORE_SIZE];
    logic [ADDR_W-1:0] w_addr;
    logic w_we;
    logic [7:0] w_wdata, r_rdata;
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rdata <= r_mem[w_addr];
    end

    logic [DIM_W-1:0] r_width, r_height;
    logic [9:0] w_w, w_h;
    always_comb begin
        w_w = (r_width == '0) ? 10'd1 : (r_width > 10'(MAX_WIDTH) ? 10'(MAX_WIDTH) : r_width);
        w_h = (r_height == '0) ? 10'd1
                               : (r_height > 10'(MAX_HEIGHT) ? 10'(MAX_HEIGHT) : r_height);
    end

    logic [ADDR_W-1:0] r_cnt;
    logic [1:0] r_op;
    logic [17:0] r_ridx;
    logic signed [13:0] r_x0, r_y0;
    logic signed [14:0] r_dx, r_dy;
    logic [5:0]  r_sbit;
    logic signed [16:0] r_ux, r_uy;
    logic [15:0] r_t;
    logic signed [35:0] r_px, r_py;
    logic signed [16:0] r_cx, r_cy;
    logic [19:0] r_wx0, r_wx1, r_wy0, r_wy1;
    logic r_fxz, r_fyz;
    logic [1:0] r_corner, r_phase;
    logic [7:0] r_val;
    logic r_inb;
    logic [ADDR_W-1:0] r_caddr;
    logic [7:0] r_pix;
    logic r_dgo;
    logic [30:0] r_qx, r_qy;

    // square root bit weight
    logic [29:0] w_bitv;
    always_comb begin
        w_bitv = 30'(1) << (2 * r_sbit);
    end
    logic [31:0] r_rt, r_nv;

    // divider
    logic w_dstart, w_ddone;
    logic [30:0] w_dnum, w_dq;
    logic signed [14:0] w_dsel;
    logic [14:0] w_dmag;
    assign w_dsel = r_dgo ? r_dx : r_dy;
    assign w_dmag = w_dsel[14] ? 15'(-w_dsel) : 15'(w_dsel);
    assign w_dnum = {1'b0, w_dmag, 15'd0};
    asp_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den({1'b0, r_rt[14:0]}), .o_done(w_ddone), .o_quot(w_dq)
    );

    // corner select
    logic signed [16:0] w_col, w_row;
    logic [19:0] w_wa, w_wb;
    logic [39:0] w_prod;
    logic [47:0] w_prod255;
    logic signed [27:0] w_lin;
    always_comb begin
        unique case (r_corner)
            2'd0: begin w_col = r_cx; w_row = r_cy; w_wa = r_wx0; w_wb = r_wy0; end
            2'd1: begin w_col = r_fxz ? r_cx : r_cx + 17'sd1; w_row = r_cy;
                        w_wa = r_wx1; w_wb = r_wy0; end
            2'd2: begin w_col = r_fxz ? r_cx : r_cx + 17'sd1;
                        w_row = r_fyz ? r_cy : r_cy + 17'sd1; w_wa = r_wx1; w_wb = r_wy1; end
            default: begin w_col = r_cx; w_row = r_fyz ? r_cy : r_cy + 17'sd1;
                        w_wa = r_wx0; w_wb = r_wy1; end
        endcase
        w_lin = 28'(w_row) * 28'(signed'({1'b0, w_w})) + 28'(w_col);
    end
    logic [39:0] r_prod;
    assign w_prod255 = 48'(r_prod) * 48'd255;

    assign w_prod = w_wa * w_wb;

    logic signed [35:0] w_t36;
    assign w_t36 = 36'(signed'({1'b0, r_t}));

    always_comb begin
        w_addr = r_cnt;
        w_we = 1'b0;
        w_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin w_we = 1'b1; end
            S_RREAD: w_addr = r_ridx[ADDR_W-1:0];
            S_CORN: begin
                w_addr = r_caddr;
                w_we = (r_phase == 2'd3) && r_inb && (r_val > r_rdata);
                w_wdata = r_val;
            end
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign w_dstart = r_dgo || ((r_state == S_DIVX) && w_ddone);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_op <= OP_NONE;
            r_width <= 10'd512;
            r_height <= 10'd512;
            o_strobe <= 1'b0;
            r_dgo <= 1'b0;
            o_pixel_value <= '0;
            o_done_op <= '0;
        end else begin
            o_strobe <= (r_state == S_DONE);
            r_dgo <= (r_state == S_SQRT) && (r_sbit == 6'd0);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) r_width <= i_cfg_data;
                else r_height <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_op <= i_opcode;
                    r_ridx <= i_read_index;
                    r_x0 <= i_start_x; r_y0 <= i_start_y;
                    r_dx <= 15'(i_end_x) - 15'(i_start_x);
                    r_dy <= 15'(i_end_y) - 15'(i_start_y);
                    r_cnt <= '0;
                    r_sbit <= 6'd15;
                    r_rt <= '0;
                    r_t <= '0;
                    unique case (t_op'(i_opcode))
                        OP_CLEAR: r_state <= S_CLEAR;
                        OP_DRAW: r_state <= S_SQRT;
                        OP_READ: r_state <= S_RREAD;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (r_cnt == ADDR_W'(STORE_SIZE - 1)) r_state <= (r_op == OP_NONE) ? S_IDLE : S_DONE;
                end
                S_RREAD: r_state <= S_RWAIT;
                S_RWAIT: begin r_pix <= r_rdata; r_state <= S_DONE; end
                S_SQRT: begin
                    if (r_sbit == 6'd15) begin
                        r_nv <= 32'(30'(r_dx * r_dx) + 30'(r_dy * r_dy));
                        r_sbit <= 6'd14;
                    end else begin
                        if (r_nv >= r_rt + 32'(w_bitv)) begin
                            r_nv <= r_nv - (r_rt + 32'(w_bitv));
                            r_rt <= (r_rt >> 1) + 32'(w_bitv);
                        end else r_rt <= r_rt >> 1;
                        if (r_sbit == 6'd0) r_state <= S_DIVX;
                        else r_sbit <= r_sbit - 6'd1;
                    end
                end
                S_DIVX: if (w_ddone) begin
                    r_qx <= w_dq;
                    r_state <= S_DIVY;
                end
                S_DIVY: if (w_ddone) begin
                    r_qy <= w_dq;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_px <= (36'(r_x0) <<< DIR_BITS) + 36'(r_ux) * w_t36;
                    r_py <= (36'(r_y0) <<< DIR_BITS) + 36'(r_uy) * w_t36;
                    r_state <= S_FRAC;
                end
                S_FRAC: begin
                    r_cx <= 17'(r_px >>> POS_BITS);
                    r_cy <= 17'(r_py >>> POS_BITS);
                    r_fxz <= (r_px[POS_BITS-1:0] == '0);
                    r_fyz <= (r_py[POS_BITS-1:0] == '0);
                    r_wx0 <= 20'(1 << POS_BITS) - 20'(r_px[POS_BITS-1:0]);
                    r_wy0 <= 20'(1 << POS_BITS) - 20'(r_py[POS_BITS-1:0]);
                    r_wx1 <= (r_px[POS_BITS-1:0] == '0) ? 20'(1 << POS_BITS)
                                                        : 20'(r_px[POS_BITS-1:0]);
                    r_wy1 <= (r_py[POS_BITS-1:0] == '0) ? 20'(1 << POS_BITS)
                                                        : 20'(r_py[POS_BITS-1:0]);
                    r_corner <= 2'd0; r_phase <= 2'd0;
                    r_state <= S_CORN;
                end
                S_CORN: begin
                    r_phase <= r_phase + 2'd1;
                    unique case (r_phase)
                        2'd0: begin
                            r_prod <= w_prod;
                            r_inb <= (w_col >= 0) && (w_row >= 0) &&
                                     (w_col < 17'(w_w)) && (w_row < 17'(w_h));
                            r_caddr <= ADDR_W'(w_lin);
                        end
                        2'd1: r_val <= 8'(w_prod255 >> (2 * POS_BITS));
                        2'd2: ;
                        default: begin
                            r_corner <= r_corner + 2'd1;
                            if (r_corner == 2'd3) begin
                                if (32'(r_t) + 32'(1 << (FRAC_BITS - 1)) <= r_rt) begin
                                    r_t <= r_t + 16'(1 << (FRAC_BITS - 1));
                                    r_state <= S_POS;
                                end else r_state <= S_DONE;
                            end
                        end
                    endcase
                end
                default: begin
                    o_done_op <= r_op;
                    o_pixel_value <= (r_op == OP_READ && 19'(r_ridx) < 19'(STORE_SIZE))
                                     ? r_pix : 8'd0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    logic w_len0;
    assign w_len0 = (r_rt == 0);
    always_comb begin
        r_ux = w_len0 ? 17'sd0 : (r_dx[14] ? -17'(r_qx[16:0]) : 17'(r_qx[16:0]));
        r_uy = w_len0 ? 17'sd0 : (r_dy[14] ? -17'(r_qy[16:0]) : 17'(r_qy[16:0]));
    end
endmodule

// ===== rtl/asp_checker.sv =====
// port-level checks for the antialiased segment plotter
// depends on asp_pkg; bound to the top level
module asp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [1:0] o_done_op,
    input logic [7:0] o_pixel_value
);
    import asp_pkg::*;
    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$past(start && !busy)) else $error("strobe right after accept");
    a_zero_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_done_op != OP_READ) |-> o_pixel_value == 8'd0) else $error("pixel");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy");
endmodule

bind antialiased_segment_plotter asp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_done_op(o_done_op), .o_pixel_value(o_pixel_value)
);
